// ===== rtl/core/tsdt_pkg.sv =====
`timescale 1ns / 1ps
package tsdt_pkg;
    localparam int SCREEN_WIDTH_DEF  = 640;
    localparam int SCREEN_HEIGHT_DEF = 480;
    localparam int ADDR_W   = 19;
    localparam int COL_W    = 10;
    localparam int ROW_W    = 9;
    localparam int WORD_W   = 32;
    localparam int MARGIN_W = 16;
    localparam int SHADE_W  = 4;
    localparam int OP_W     = 3;
    localparam int TEX_AW   = 16;
    localparam int TEX_DEPTH = 65536;
    localparam int CFG_IDX_W = 1;
    localparam logic [WORD_W-1:0] MARGIN_RESET = 32'd168;
    localparam logic [7:0] ALPHA_SHADED = 8'hFE;

    typedef enum logic [OP_W-1:0] {
        OP_LOAD_TEXEL = 3'd0,
        OP_SPAN_START = 3'd1,
        OP_SPAN_GRAD  = 3'd2,
        OP_STEP_PIXEL = 3'd3,
        OP_WRITE_DEPTH = 3'd4
    } op_t;

    localparam logic [CFG_IDX_W-1:0] CFG_TRANSPARENT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MARGIN      = 1'd1;

    typedef struct packed {
        logic [ADDR_W-1:0] pixel_address;
        logic [WORD_W-1:0] color;
        logic              write_enable;
        logic              span_done;
    } result_t;

    typedef struct packed {
        logic [OP_W-1:0]   opcode;
        logic [ADDR_W-1:0] index;
        logic [WORD_W-1:0] texel;
        logic [ROW_W-1:0]  row;
        logic [COL_W-1:0]  x_start;
        logic [COL_W-1:0]  x_end;
        logic [WORD_W-1:0] u_val;
        logic [WORD_W-1:0] v_val;
        logic [WORD_W-1:0] w_val;
        logic [WORD_W-1:0] depth_val;
        logic [SHADE_W-1:0] shade;
    } item_t;

    function automatic logic [WORD_W-1:0] apply_shade(input logic [SHADE_W-1:0] sh,
                                                      input logic [WORD_W-1:0] c);
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        r = c[23:16] >> sh;
        g = c[15:8] >> sh;
        b = c[7:0] >> sh;
        return {ALPHA_SHADED, r, g, b};
    endfunction
endpackage

// ===== rtl/core/tsdt_if.sv =====
`timescale 1ns / 1ps
interface tsdt_in_if;
    import tsdt_pkg::*;
    logic  valid;
    logic  ready;
    item_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface tsdt_out_if;
    import tsdt_pkg::*;
    logic    valid;
    logic    ready;
    result_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/core/tsdt_ram.sv =====
`timescale 1ns / 1ps
module tsdt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ===== rtl/core/tsdt_div.sv =====
`timescale 1ns / 1ps
// Signed restoring divider, one quotient bit a cycle; gives the low 8 bits
// of the truncated quotient, zero for a zero divisor.
module tsdt_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] num,
    input  logic [31:0] den,
    output logic        done,
    output logic [7:0]  quot
);
    logic [31:0] rem_reg, rem_next;
    logic [31:0] q_reg, q_next;
    logic [31:0] d_reg;
    logic        neg_reg, zero_reg;
    logic [5:0]  cnt_reg;
    logic        busy_reg;
    logic [32:0] trial;
    logic [31:0] qneg;

    always_comb
    begin
        trial    = {rem_reg, q_reg[31]} - {1'b0, d_reg};
        if (!trial[32])
        begin
            rem_next = trial[31:0];
            q_next   = {q_reg[30:0], 1'b1};
        end
        else
        begin
            // remainder stays below the divisor, so its top bit is clear
            rem_next = {rem_reg[30:0], q_reg[31]};
            q_next   = {q_reg[30:0], 1'b0};
        end
    end

    assign qneg = ~q_reg + 32'd1;
    assign quot = zero_reg ? 8'd0 : (neg_reg ? qneg[7:0] : q_reg[7:0]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done     <= 1'b0;
            cnt_reg  <= '0;
            rem_reg  <= '0;
            q_reg    <= '0;
            d_reg    <= '0;
            neg_reg  <= 1'b0;
            zero_reg <= 1'b0;
        end
        else
        begin
            done <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 6'd32;
                rem_reg  <= '0;
                q_reg    <= num[31] ? ~num + 32'd1 : num;
                d_reg    <= den[31] ? ~den + 32'd1 : den;
                neg_reg  <= num[31] ^ den[31];
                zero_reg <= (den == 32'd0);
            end
            else if (busy_reg)
            begin
                rem_reg <= rem_next;
                q_reg   <= q_next;
                cnt_reg <= cnt_reg - 6'd1;
                if (cnt_reg == 6'd1)
                begin
                    busy_reg <= 1'b0;
                    done     <= 1'b1;
                end
            end
        end
    end
endmodule

// ===== rtl/core/textured_span_depth_test.sv =====
`timescale 1ns / 1ps
// Textured span with depth test.
// in_ch carries command beats: texel loads, depth entry loads, span start,
// span gradients and pixel steps. out_ch carries one result beat for each
// pixel step on a span that is not yet finished; other commands give none.
// Load and set-up beats, and a step on a finished span, go from S_DREAD
// back to idle. A pixel step reads the depth entry in S_DREAD; if the
// depth test passes, it runs the u/w and v/w divisions in parallel on two
// bit-serial dividers (S_DIV), reads the texel (S_TREAD), and in S_TEST
// writes the depth back unless the texel is transparent. When the depth
// test fails, the step goes from S_DREAD straight to S_OUT. In every case
// the next beat is taken only once the result has been taken.
// The result sits in an output register; the block takes no new beat while
// a result waits, so a stalled receiver holds the block with its result.
// Reset clears the span registers and steps and returns the configuration
// to its defaults; texture and depth memories are not cleared and must be
// written before they are read. The user must keep cfg writes, taken at an
// edge at which cfg_we is high, to idle; the block does not enforce it.
module textured_span_depth_test
    import tsdt_pkg::*;
#(
    parameter int SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [tsdt_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [tsdt_pkg::WORD_W-1:0]   cfg_data,
    tsdt_in_if.sink                       in_ch,
    tsdt_out_if.source                    out_ch
);
    localparam int DEPTH_SIZE = SCREEN_WIDTH * SCREEN_HEIGHT;
    localparam int DEPTH_AW   = $clog2(DEPTH_SIZE);

    typedef enum logic [2:0] {
        S_IDLE, S_DREAD, S_DIV, S_TREAD, S_TEST, S_OUT
    } state_t;

    state_t state_reg;
    item_t  item_reg;
    logic [WORD_W-1:0] transparent_reg;
    logic [MARGIN_W-1:0] margin_reg;
    logic [COL_W-1:0] cur_reg, end_reg;
    logic [ADDR_W-1:0] row_base_reg;
    logic [WORD_W-1:0] u_reg, v_reg, w_reg, z_reg;
    logic [WORD_W-1:0] su_reg, sv_reg, sw_reg, sz_reg;
    logic [SHADE_W-1:0] shade_reg;
    logic [ADDR_W-1:0] addr_reg;
    logic last_reg;
    result_t res_reg;

    // memories
    logic              tex_we, dep_we;
    logic [TEX_AW-1:0] tex_waddr, tex_raddr;
    logic [WORD_W-1:0] tex_wdata, tex_rdata;
    logic [DEPTH_AW-1:0] dep_waddr, dep_raddr;
    logic [WORD_W-1:0] dep_wdata, dep_rdata;

    logic div_start, du_done, dv_done;
    logic [7:0] tu, tv;

    logic in_fire;
    logic [ADDR_W:0] addr_sum;
    logic [ADDR_W-1:0] pix_addr;
    logic addr_ok;
    logic signed [WORD_W:0] lead;
    logic [ADDR_W+COL_W-1:0] row_prod;

    assign in_ch.ready = (state_reg == S_IDLE);
    assign in_fire     = in_ch.valid && in_ch.ready;
    assign out_ch.valid = (state_reg == S_OUT);
    assign out_ch.data  = res_reg;

    assign addr_sum = {1'b0, row_base_reg} + {{(ADDR_W+1-COL_W){1'b0}}, cur_reg};
    assign pix_addr = addr_sum[ADDR_W-1:0];
    assign addr_ok  = ({13'd0, pix_addr} < 32'(DEPTH_SIZE));
    assign row_prod = (ADDR_W+COL_W)'(item_reg.row) * (ADDR_W+COL_W)'(SCREEN_WIDTH);
    assign lead = $signed({dep_rdata[WORD_W-1], dep_rdata})
                - $signed({z_reg[WORD_W-1], z_reg});

    // write ports: loads from the command, write-back from the pixel test
    always_comb
    begin
        tex_we    = (state_reg == S_DREAD) && (item_reg.opcode == OP_LOAD_TEXEL)
                    && (item_reg.index[ADDR_W-1:TEX_AW] == '0);
        tex_waddr = item_reg.index[TEX_AW-1:0];
        tex_wdata = item_reg.texel;
        tex_raddr = {tv, tu};
        dep_raddr = pix_addr[DEPTH_AW-1:0];
        if (state_reg == S_TEST)
        begin
            dep_we    = (tex_rdata != transparent_reg);
            dep_waddr = addr_reg[DEPTH_AW-1:0];
            dep_wdata = z_reg;
        end
        else
        begin
            dep_we    = (state_reg == S_DREAD) && (item_reg.opcode == OP_WRITE_DEPTH)
                        && ({13'd0, item_reg.index} < 32'(DEPTH_SIZE));
            dep_waddr = item_reg.index[DEPTH_AW-1:0];
            dep_wdata = item_reg.depth_val;
        end
    end

    tsdt_ram #(.WIDTH(WORD_W), .DEPTH(TEX_DEPTH)) u_tex (
        .clk(clk), .we(tex_we), .waddr(tex_waddr), .wdata(tex_wdata),
        .raddr(tex_raddr), .rdata(tex_rdata));

    tsdt_ram #(.WIDTH(WORD_W), .DEPTH(DEPTH_SIZE)) u_dep (
        .clk(clk), .we(dep_we), .waddr(dep_waddr), .wdata(dep_wdata),
        .raddr(dep_raddr), .rdata(dep_rdata));

    tsdt_div u_div_u (.clk(clk), .rst_n(rst_n), .start(div_start), .num(u_reg),
                      .den(w_reg), .done(du_done), .quot(tu));
    tsdt_div u_div_v (.clk(clk), .rst_n(rst_n), .start(div_start), .num(v_reg),
                      .den(w_reg), .done(dv_done), .quot(tv));

    assign div_start = (state_reg == S_DREAD) && (item_reg.opcode == OP_STEP_PIXEL)
                       && addr_ok && (lead > $signed({17'd0, margin_reg}));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            transparent_reg <= '0;
            margin_reg      <= MARGIN_RESET[MARGIN_W-1:0];
            cur_reg <= '0; end_reg <= '0; row_base_reg <= '0;
            u_reg <= '0; v_reg <= '0; w_reg <= '0; z_reg <= '0;
            su_reg <= '0; sv_reg <= '0; sw_reg <= '0; sz_reg <= '0;
            shade_reg <= '0;
            item_reg  <= '0;
            addr_reg  <= '0;
            last_reg  <= 1'b0;
            res_reg   <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_TRANSPARENT: transparent_reg <= cfg_data;
                    CFG_MARGIN:      margin_reg <= cfg_data[MARGIN_W-1:0];
                    default: ;
                endcase
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_fire)
                    begin
                        item_reg  <= in_ch.data;
                        state_reg <= S_DREAD;
                    end
                end
                S_DREAD:
                begin
                    // depth entry for the current column is now on dep_rdata
                    state_reg <= S_IDLE;
                    case (item_reg.opcode)
                        OP_SPAN_START:
                        begin
                            cur_reg <= item_reg.x_start;
                            end_reg <= item_reg.x_end;
                            row_base_reg <= row_prod[ADDR_W-1:0];
                            u_reg <= item_reg.u_val; v_reg <= item_reg.v_val;
                            w_reg <= item_reg.w_val; z_reg <= item_reg.depth_val;
                            shade_reg <= item_reg.shade;
                        end
                        OP_SPAN_GRAD:
                        begin
                            su_reg <= item_reg.u_val; sv_reg <= item_reg.v_val;
                            sw_reg <= item_reg.w_val; sz_reg <= item_reg.depth_val;
                        end
                        OP_STEP_PIXEL:
                        begin
                            if (cur_reg < end_reg)
                            begin
                                addr_reg <= pix_addr;
                                last_reg <= (cur_reg + COL_W'(1)) == end_reg;
                                res_reg.pixel_address <= pix_addr;
                                res_reg.color <= '0;
                                res_reg.write_enable <= 1'b0;
                                res_reg.span_done <= (cur_reg + COL_W'(1)) == end_reg;
                                state_reg <= div_start ? S_DIV : S_OUT;
                                if (!div_start)
                                begin
                                    // fail: advance accumulators now
                                    u_reg <= u_reg + su_reg; v_reg <= v_reg + sv_reg;
                                    w_reg <= w_reg + sw_reg; z_reg <= z_reg + sz_reg;
                                    cur_reg <= cur_reg + COL_W'(1);
                                end
                            end
                        end
                        default: ;
                    endcase
                end
                S_DIV:
                begin
                    if (du_done && dv_done)
                    begin
                        state_reg <= S_TREAD;
                    end
                end
                S_TREAD:
                begin
                    state_reg <= S_TEST;
                end
                S_TEST:
                begin
                    if (tex_rdata != transparent_reg)
                    begin
                        res_reg.write_enable <= 1'b1;
                        res_reg.color <= (shade_reg != '0)
                            ? apply_shade(shade_reg, tex_rdata) : tex_rdata;
                    end
                    u_reg <= u_reg + su_reg; v_reg <= v_reg + sv_reg;
                    w_reg <= w_reg + sw_reg; z_reg <= z_reg + sz_reg;
                    cur_reg <= cur_reg + COL_W'(1);
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (out_ch.ready)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // both dividers start together and must finish together
    assert property (@(posedge clk) disable iff (!rst_n) du_done == dv_done)
        else $error("dividers out of step");
    // a result beat reports the column it addressed
    assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid |-> out_ch.data.pixel_address == addr_reg)
        else $error("result address mismatch");
    // a colour is only given with write enable
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && !out_ch.data.write_enable) |-> out_ch.data.color == '0)
        else $error("colour without write");
    // the texel test always follows its texel read
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_TEST) |-> $past(state_reg) == S_TREAD)
        else $error("test without texel read");
    // span_done matches last_reg
    assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid |-> out_ch.data.span_done == last_reg)
        else $error("span_done mismatch");
endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
module testbench;
    import tsdt_pkg::*;

    localparam int          DEPTH_SIZE  = SCREEN_WIDTH_DEF * SCREEN_HEIGHT_DEF;
    localparam int          CYCLE_LIMIT = 2000000;
    localparam int          SETTLE      = 60;
    localparam logic [2:0]  OP_SPARE    = 3'd5;
    localparam logic [2:0]  OP_TOP      = 3'd7;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [WORD_W-1:0] cfg_data;

    tsdt_in_if  in_ch();
    tsdt_out_if out_ch();

    textured_span_depth_test dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    // Clock: 8 ns period.
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Pending command beats and the pixel results they are known to cause.
    item_t   cmd_queue[$];
    result_t pixel_queue[$];

    // Shadow of the block: memories as sparse maps, so that an entry that
    // was never written is simply absent.
    logic [31:0] tex_mem[int];
    logic [31:0] depth_mem[int];
    logic [9:0]  cur_col;
    logic [9:0]  end_col;
    logic [18:0] row_base;
    logic [31:0] u_acc, v_acc, w_acc, z_acc;
    logic [31:0] u_step, v_step, w_step, z_step;
    logic [3:0]  shade_sh;
    logic [31:0] transparent;
    logic [15:0] margin;

    int  mismatches = 0;
    int  pixels_seen = 0;
    int  beats_sent = 0;
    int  cycles = 0;
    int  written_pixels = 0;
    bit  no_idle;
    bit  hold_pending;
    bit  hold_taken;

    // Texture coordinate: low byte of the truncated quotient, zero divisor
    // gives zero.
    function automatic logic [7:0] coord_of(logic [31:0] num, logic [31:0] den);
        longint n;
        longint d;
        longint q;
        n = longint'($signed(num));
        d = longint'($signed(den));
        if (d == 0)
            return 8'd0;
        q = n / d;
        return q[7:0];
    endfunction

    function automatic int texel_addr();
        return int'({coord_of(v_acc, w_acc), coord_of(u_acc, w_acc)});
    endfunction

    function automatic bit depth_wins(int a);
        longint lead;
        lead = longint'($signed(depth_mem[a])) - longint'($signed(z_acc));
        return lead > longint'(margin);
    endfunction

    function automatic item_t blank_item(op_t op);
        item_t it;
        it = '0;
        it.opcode = op;
        return it;
    endfunction

    // Advance the shadow by one command beat and queue the pixel it causes.
    task automatic push_cmd(item_t it);
        result_t r;
        int      a;
        logic [31:0] c;
        case (it.opcode)
            OP_LOAD_TEXEL:
                if (it.index < TEX_DEPTH)
                    tex_mem[it.index] = it.texel;
            OP_WRITE_DEPTH:
                if (it.index < DEPTH_SIZE)
                    depth_mem[it.index] = it.depth_val;
            OP_SPAN_START:
            begin
                cur_col  = it.x_start;
                end_col  = it.x_end;
                row_base = 19'(int'(it.row) * SCREEN_WIDTH_DEF);
                u_acc = it.u_val;
                v_acc = it.v_val;
                w_acc = it.w_val;
                z_acc = it.depth_val;
                shade_sh = it.shade;
            end
            OP_SPAN_GRAD:
            begin
                u_step = it.u_val;
                v_step = it.v_val;
                w_step = it.w_val;
                z_step = it.depth_val;
            end
            OP_STEP_PIXEL:
                if (cur_col < end_col)
                begin
                    r = '0;
                    r.pixel_address = row_base + 19'(cur_col);
                    r.span_done = (11'(cur_col) + 11'd1) == 11'(end_col);
                    a = int'(r.pixel_address);
                    if (a < DEPTH_SIZE && depth_wins(a))
                    begin
                        c = tex_mem[texel_addr()];
                        if (c != transparent)
                        begin
                            depth_mem[a] = z_acc;
                            r.write_enable = 1'b1;
                            if (shade_sh != 0)
                                r.color = {8'hFE, 8'(c[23:16] >> shade_sh),
                                           8'(c[15:8] >> shade_sh), 8'(c[7:0] >> shade_sh)};
                            else
                                r.color = c;
                        end
                    end
                    u_acc += u_step;
                    v_acc += v_step;
                    w_acc += w_step;
                    z_acc += z_step;
                    cur_col = cur_col + 10'd1;
                    pixel_queue.push_back(r);
                end
            default: ;
        endcase
        cmd_queue.push_back(it);
    endtask

    // Step one pixel; first load the depth entry and texel it will read if
    // they were never written, so no unwritten entry is used.
    task automatic step_pixel();
        item_t it;
        int    a;
        int    t;
        if (cur_col < end_col)
        begin
            a = int'(row_base + 19'(cur_col));
            if (a < DEPTH_SIZE && !depth_mem.exists(a))
            begin
                it = blank_item(OP_WRITE_DEPTH);
                it.index = 19'(a);
                it.depth_val = z_acc + 32'(margin) + 32'($urandom_range(3000)) - 32'd400;
                if ($urandom_range(9) == 0)
                    it.depth_val = $urandom;
                push_cmd(it);
            end
            if (a < DEPTH_SIZE && depth_wins(a))
            begin
                t = texel_addr();
                if (!tex_mem.exists(t))
                begin
                    it = blank_item(OP_LOAD_TEXEL);
                    it.index = 19'(t);
                    it.texel = ($urandom_range(4) == 0) ? transparent : $urandom;
                    push_cmd(it);
                end
            end
        end
        push_cmd(blank_item(OP_STEP_PIXEL));
    endtask

    task automatic start_span(logic [8:0] row, logic [9:0] xs, logic [9:0] xe,
                              logic [31:0] u, logic [31:0] v, logic [31:0] w,
                              logic [31:0] z, logic [3:0] sh);
        item_t it;
        it = blank_item(OP_SPAN_START);
        it.row = row; it.x_start = xs; it.x_end = xe;
        it.u_val = u; it.v_val = v; it.w_val = w; it.depth_val = z; it.shade = sh;
        push_cmd(it);
    endtask

    task automatic set_steps(logic [31:0] u, logic [31:0] v, logic [31:0] w,
                             logic [31:0] z);
        item_t it;
        it = blank_item(OP_SPAN_GRAD);
        it.u_val = u; it.v_val = v; it.w_val = w; it.depth_val = z;
        push_cmd(it);
    endtask

    // A well-formed span: start, steps, then its pixels, now and then with
    // two extra steps past the end.
    task automatic random_span();
        logic [9:0] xs;
        int len;
        int k;
        xs  = 10'($urandom_range(639));
        len = $urandom_range(1, 10);
        if (int'(xs) + len > 640)
            len = 640 - int'(xs);
        start_span((($urandom_range(15) == 0) ? 9'($urandom) : 9'($urandom_range(479))),
                   xs, 10'(int'(xs) + len),
                   ($urandom_range(3) == 0) ? $urandom : 32'($signed($urandom_range(200000)) - 100000),
                   ($urandom_range(3) == 0) ? $urandom : 32'($signed($urandom_range(200000)) - 100000),
                   ($urandom_range(7) == 0) ? $urandom : 32'($signed($urandom_range(800)) - 400),
                   32'($signed($urandom_range(100000)) - 50000),
                   ($urandom_range(1) == 0) ? 4'd0 : 4'($urandom_range(15)));
        set_steps(($urandom_range(5) == 0) ? $urandom : 32'($signed($urandom_range(4000)) - 2000),
                  ($urandom_range(5) == 0) ? $urandom : 32'($signed($urandom_range(4000)) - 2000),
                  ($urandom_range(5) == 0) ? $urandom : 32'($signed($urandom_range(16)) - 8),
                  32'($signed($urandom_range(600)) - 300));
        for (k = 0; k < len + (($urandom_range(4) == 0) ? 2 : 0); k++)
            step_pixel();
    endtask

    // A beat with random content in every field; a pixel step goes through step_pixel.
    task automatic noise_beat();
        item_t it;
        it = ($bits(item_t))'({$urandom, $urandom, $urandom, $urandom, $urandom,
                               $urandom, $urandom, $urandom, $urandom});
        if (it.opcode == OP_STEP_PIXEL)
            step_pixel();
        else
            push_cmd(it);
    endtask

    task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [WORD_W-1:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        if (idx == CFG_TRANSPARENT)
            transparent = val;
        else
            margin = val[15:0];
    endtask

    // Hold the sender off until every beat has gone and every pixel has
    // arrived, then let the block finish any work that gives no result.
    task automatic drain();
        wait (cmd_queue.size() == 0 && pixel_queue.size() == 0);
        repeat (SETTLE) @(posedge clk);
    endtask

    // Driver: hold a beat until it is taken, idle in short random bursts.
    int gap;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_ch.valid <= 1'b0;
            in_ch.data  <= '0;
            gap = 0;
        end
        else
        begin
            if (in_ch.valid && in_ch.ready)
            begin
                void'(cmd_queue.pop_front());
                beats_sent++;
            end
            if (!(in_ch.valid && !in_ch.ready))
            begin
                if (!no_idle && gap == 0 && $urandom_range(9) == 0)
                    gap = $urandom_range(1, 5);
                if (gap > 0)
                begin
                    gap--;
                    in_ch.valid <= 1'b0;
                end
                else if (cmd_queue.size() > 0)
                begin
                    in_ch.valid <= 1'b1;
                    in_ch.data  <= cmd_queue[0];
                end
                else
                    in_ch.valid <= 1'b0;
            end
        end
    end

    // Receiver back-pressure: random bursts, plus one long hold-off.
    int stall;
    int long_hold;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
            stall = 0;
            long_hold = 0;
            hold_taken = 1'b0;
        end
        else
        begin
            if (hold_pending && !hold_taken)
            begin
                hold_taken = 1'b1;
                long_hold = 400;
            end
            if (long_hold > 0)
            begin
                long_hold--;
                out_ch.ready <= 1'b0;
            end
            else
            begin
                if (!no_idle && stall == 0 && $urandom_range(7) == 0)
                    stall = $urandom_range(1, 5);
                if (stall > 0)
                begin
                    stall--;
                    out_ch.ready <= 1'b0;
                end
                else
                    out_ch.ready <= 1'b1;
            end
        end
    end

    // Monitor: compare each result beat with the oldest expected pixel.
    result_t want;
    always @(posedge clk)
    begin
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            pixels_seen++;
            if (pixel_queue.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat: addr %0d colour %h we %b done %b",
                             out_ch.data.pixel_address, out_ch.data.color,
                             out_ch.data.write_enable, out_ch.data.span_done);
            end
            else
            begin
                want = pixel_queue.pop_front();
                if (want.write_enable)
                    written_pixels++;
                if (out_ch.data.pixel_address != want.pixel_address
                    || out_ch.data.color != want.color
                    || out_ch.data.write_enable != want.write_enable
                    || out_ch.data.span_done != want.span_done)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("pixel %0d: want addr %0d colour %h we %b done %b, got addr %0d colour %h we %b done %b",
                                 pixels_seen, want.pixel_address, want.color,
                                 want.write_enable, want.span_done,
                                 out_ch.data.pixel_address, out_ch.data.color,
                                 out_ch.data.write_enable, out_ch.data.span_done);
                end
            end
        end
    end

    // Watchdog.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("testbench: done, errors");
            $finish;
        end
    end

    int phase;
    int n;
    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = CFG_TRANSPARENT;
        cfg_data = '0;
        no_idle = 1'b0; hold_pending = 1'b0;
        cur_col = 0; end_col = 0; row_base = 0;
        u_acc = 0; v_acc = 0; w_acc = 0; z_acc = 0;
        u_step = 0; v_step = 0; w_step = 0; z_step = 0; shade_sh = 0;
        transparent = 32'd0;
        margin = 16'd168;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Directed: store edges, ignored writes, steps with no span,
        // unused opcodes, zero divisor, most negative quotient, big shade,
        // transparency, a finished span and a row beyond the screen.
        begin
            item_t it;
            it = blank_item(OP_LOAD_TEXEL); it.index = 19'd65535; it.texel = 32'hFFFF_FFFF;
            push_cmd(it);
            it.index = 19'd65536; it.texel = 32'h1234_5678; push_cmd(it);
            it = blank_item(OP_WRITE_DEPTH); it.index = 19'd307199; it.depth_val = 32'h7FFF_FFFF;
            push_cmd(it);
            it.index = 19'h7FFFF; it.depth_val = 32'h8000_0000; push_cmd(it);
            push_cmd(blank_item(OP_STEP_PIXEL));
            for (int o = OP_SPARE; o <= OP_TOP; o++)
            begin
                it = '1; it.opcode = 3'(o); push_cmd(it);
            end
            start_span(9'd0, 10'd0, 10'd2, 32'h7FFF_FFFF, 32'h8000_0000, 32'd0,
                       32'h8000_0000, 4'd0);
            set_steps(32'd0, 32'd0, 32'hFFFF_FFFF, 32'd1);
            step_pixel(); step_pixel(); step_pixel();
            start_span(9'd479, 10'd632, 10'd640, 32'h8000_0000, 32'h8000_0000,
                       32'hFFFF_FFFF, 32'd0, 4'd8);
            set_steps(32'h7FFF_FFFF, 32'h8000_0000, 32'd0, 32'hFFFF_FFFF);
            step_pixel(); step_pixel();
            start_span(9'd479, 10'd638, 10'd640, 32'd77, 32'd5, 32'd3, 32'd0, 4'd15);
            step_pixel(); step_pixel();
            start_span(9'd511, 10'd1023, 10'd1023, 32'd0, 32'd0, 32'd1, 32'd0, 4'd0);
            step_pixel();
            start_span(9'd511, 10'd100, 10'd102, 32'd0, 32'd0, 32'd1, 32'd0, 4'd1);
            step_pixel(); step_pixel();
        end
        drain();

        // Random phases, each under its own register setting.
        for (phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0: begin write_cfg(CFG_TRANSPARENT, 32'hFFFF_FFFF); write_cfg(CFG_MARGIN, 32'd0); end
                1: begin write_cfg(CFG_TRANSPARENT, $urandom); write_cfg(CFG_MARGIN, 32'd65535); end
                2: begin write_cfg(CFG_TRANSPARENT, 32'd0); write_cfg(CFG_MARGIN, $urandom_range(65535)); end
                default: begin write_cfg(CFG_TRANSPARENT, $urandom); write_cfg(CFG_MARGIN, 32'd168); end
            endcase
            // The final phase runs with no idling on either side.
            no_idle = (phase == 3);
            n = cmd_queue.size() + beats_sent;
            while (cmd_queue.size() + beats_sent - n < 180)
            begin
                if ($urandom_range(5) == 0)
                    noise_beat();
                else
                    random_span();
                // Part way into the first phase, let the receiver stall
                // long enough for the block to back up its input.
                if (phase == 0 && cmd_queue.size() + beats_sent - n > 40 && long_hold == 0
                    && !hold_pending && cmd_queue.size() > 20 && pixels_seen < 40)
                    hold_pending = 1'b1;
                @(posedge clk);
            end
            drain();
        end

        $display("sent %0d beats, checked %0d pixels (%0d drawn) over 5 register settings",
                 beats_sent, pixels_seen, written_pixels);
        if (mismatches == 0)
            $display("testbench: done, clean");
        else
        begin
            $display("%0d mismatches", mismatches);
            $display("testbench: done, errors");
        end
        $finish;
    end
endmodule
